/* src/mhpq_pkg.sv */
// shared types, codes and helpers for the min-heap priority queue
package mhpq_pkg;

	localparam int HEAP_DEPTH_DEF = 64;
	localparam int KEY_W = 32;
	localparam int IDX_W = 16;

	typedef enum logic {
		MODE_INSERT,
		MODE_POP
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_FULL,
		ST_EMPTY
	} status_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [IDX_W-1:0] first_index;
		logic [IDX_W-1:0] second_index;
	} entry_t;

	typedef struct packed {
		mode_t mode;
		logic [IDX_W-1:0] first_index;
		logic [IDX_W-1:0] second_index;
		logic signed [KEY_W-1:0] key;
	} in_item_t;

	typedef struct packed {
		status_t status;
		logic [IDX_W-1:0] out_first_index;
		logic [IDX_W-1:0] out_second_index;
		logic signed [KEY_W-1:0] out_key;
	} out_item_t;

	typedef struct packed {
		logic valid;
		mode_t op;
		logic placed;
	} tok_ctl_t;

	function automatic logic key_less(input logic signed [KEY_W-1:0] a,
		input logic signed [KEY_W-1:0] b);
		return a < b;
	endfunction

endpackage

/* src/mhpq_cell.sv */
// one heap level: its slots plus the compare and swap step for a passing token
module mhpq_cell #(
	parameter int LEVEL = 0,
	parameter int NW = 7,
	parameter int LVL_DEPTH = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mhpq_pkg::tok_ctl_t tok_in,
	input  logic [NW-1:0]      node_in,
	input  logic [NW-1:0]      lim_in,
	input  logic [NW-1:0]      path_in,
	input  mhpq_pkg::entry_t   ent_in,
	output mhpq_pkg::tok_ctl_t tok_out,
	output logic [NW-1:0]      node_out,
	output logic [NW-1:0]      lim_out,
	output logic [NW-1:0]      path_out,
	output mhpq_pkg::entry_t   ent_out,
	input  logic               bc_rd,
	input  logic [NW-1:0]      bc_node,
	input  logic               creq,
	input  logic [NW-1:0]      cnode,
	output logic               creq_out,
	output logic [NW-1:0]      cnode_out,
	input  mhpq_pkg::entry_t   cd0,
	input  mhpq_pkg::entry_t   cd1,
	output mhpq_pkg::entry_t   rd0,
	output mhpq_pkg::entry_t   rd1,
	output logic               active,
	output logic               done
);
	import mhpq_pkg::*;

	localparam int AW = (LVL_DEPTH > 1) ? $clog2(LVL_DEPTH) : 1;

	tok_ctl_t ctl_q;
	logic ph_q;
	logic [NW-1:0] node_q;
	logic [NW-1:0] lim_q;
	logic [NW-1:0] path_q;
	entry_t ent_q;

	logic phase0;
	logic phase1;
	logic [NW:0] lchild;
	logic lv;
	logic rv;
	logic swap;
	logic sel_l;
	logic sel_r;
	logic signed [KEY_W-1:0] best_key;
	logic we;
	entry_t wd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
			ph_q <= 1'b0;
		end else if (tok_in.valid) begin
			ctl_q <= tok_in;
			ph_q <= 1'b0;
		end else if (ctl_q.valid) begin
			if (!ph_q) begin
				ph_q <= 1'b1;
			end else begin
				ctl_q.valid <= 1'b0;
				ph_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_in.valid) begin
			node_q <= node_in;
			lim_q <= lim_in;
			path_q <= path_in;
			ent_q <= ent_in;
		end
	end

	assign phase0 = ctl_q.valid && !ph_q;
	assign phase1 = ctl_q.valid && ph_q;
	assign active = ctl_q.valid;

	// pop reads both children from the next level
	assign creq_out = phase0 && (ctl_q.op == MODE_POP);
	assign cnode_out = node_q;

	assign lchild = {node_q, 1'b0};
	assign lv = lchild <= {1'b0, lim_q};
	assign rv = lchild < {1'b0, lim_q};

	always_comb begin
		we = 1'b0;
		wd = ent_q;
		done = 1'b0;
		swap = 1'b0;
		sel_l = 1'b0;
		sel_r = 1'b0;
		best_key = ent_q.key;
		tok_out = '0;
		node_out = node_q;
		lim_out = lim_q;
		path_out = path_q;
		ent_out = ent_q;
		if (phase1) begin
			case (ctl_q.op)
				MODE_INSERT: begin
					if (node_q == lim_q) begin
						we = 1'b1;
						done = 1'b1;
					end else begin
						// once placed, every slot below on the insert path shifts down one level
						swap = ctl_q.placed || key_less(ent_q.key, rd0.key);
						we = swap;
						tok_out.valid = 1'b1;
						tok_out.op = MODE_INSERT;
						tok_out.placed = ctl_q.placed || swap;
						ent_out = swap ? rd0 : ent_q;
						node_out = {node_q[NW-2:0], path_q[NW-1]};
						path_out = {path_q[NW-2:0], 1'b0};
					end
				end
				MODE_POP: begin
					we = 1'b1;
					sel_l = lv && key_less(cd0.key, ent_q.key);
					best_key = sel_l ? cd0.key : ent_q.key;
					sel_r = rv && key_less(cd1.key, best_key);
					if (sel_r) begin
						wd = cd1;
						tok_out.valid = 1'b1;
						tok_out.op = MODE_POP;
						node_out = lchild[NW-1:0] | NW'(1);
					end else if (sel_l) begin
						wd = cd0;
						tok_out.valid = 1'b1;
						tok_out.op = MODE_POP;
						node_out = lchild[NW-1:0];
					end else begin
						done = 1'b1;
					end
				end
				default: begin
					we = 1'b0;
				end
			endcase
		end
	end

	if (LVL_DEPTH == 1) begin : g_reg
		entry_t slot_q;

		always_ff @(posedge clk) begin
			if (we) begin
				slot_q <= wd;
			end
		end

		assign rd0 = slot_q;
		assign rd1 = slot_q;
	end else begin : g_mem
		entry_t mem [LVL_DEPTH];
		logic [NW-1:0] lnode;
		logic [AW-1:0] ra0;
		logic [AW-1:0] ra1;
		entry_t rd0_q;
		entry_t rd1_q;

		assign lnode = {cnode[NW-2:0], 1'b0};

		always_comb begin
			ra0 = node_q[AW-1:0];
			if (bc_rd) begin
				ra0 = bc_node[AW-1:0];
			end
			if (creq) begin
				ra0 = lnode[AW-1:0];
			end
			ra1 = ra0 | AW'(1);
		end

		always_ff @(posedge clk) begin
			if (we) begin
				mem[node_q[AW-1:0]] <= wd;
			end
			rd0_q <= mem[ra0];
			rd1_q <= mem[ra1];
		end

		assign rd0 = rd0_q;
		assign rd1 = rd1_q;
	end

endmodule

/* src/min_heap_priority_queue.sv */
// top level of the min-heap priority queue: command sequencer and chain of level cells
//
// command port: a transaction is taken on a rising edge with start high and busy low.
// cmd.mode selects insert (entry from cmd) or pop of the smallest key.
// every transaction returns exactly one result on result, marked by done for one cycle;
// the receiver cannot hold it off. status is ok, full (insert at HEAP_DEPTH entries)
// or empty (pop of an empty queue); the entry fields are zero except on a good pop.
// full and empty answer in the cycle after the transaction. a pop of the only entry
// answers without sending a token down the chain. each heap level is one cell with its
// own slot memory, and in each cell the token is first read, then compared and
// written. busy stays high until the cycle in which done shows, so a new command may be
// taken in that cycle. one transaction is in the chain at a time.
// reset empties the queue at once; slot contents are not cleared and are never read
// before being written.
module min_heap_priority_queue #(
	parameter int HEAP_DEPTH = mhpq_pkg::HEAP_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  mhpq_pkg::in_item_t  cmd,
	output logic                done,
	output mhpq_pkg::out_item_t result
);
	import mhpq_pkg::*;

	localparam int NW = $clog2(HEAP_DEPTH + 1);
	localparam int NLV = NW;
	localparam int LW = $clog2(NLV);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LAUNCH,
		S_POPRD,
		S_POPDAT,
		S_RUN
	} state_t;

	state_t state_q;
	logic [NW-1:0] count_q;
	logic [LW-1:0] lc_q;
	logic [NW-1:0] lim_q;
	logic [NW-1:0] path_q;
	entry_t ent_q;
	logic done_q;
	out_item_t res_q;

	logic acc;
	logic [NW-1:0] q_ins;
	logic [LW-1:0] lp_ins;
	logic [LW-1:0] lp_pop;
	logic [NW-1:0] path_ins;
	logic [NW-1:0] bc_node;
	logic [NLV-1:0] done_v;
	logic [NLV-1:0] active_v;

	tok_ctl_t tok_c [NLV+1];
	logic [NW-1:0] node_c [NLV+1];
	logic [NW-1:0] lim_c [NLV+1];
	logic [NW-1:0] path_c [NLV+1];
	entry_t ent_c [NLV+1];
	logic creq_c [NLV+1];
	logic [NW-1:0] cnode_c [NLV+1];
	entry_t rd0_a [NLV];
	entry_t rd1_a [NLV];

	function automatic logic [LW-1:0] msb_pos(input logic [NW-1:0] x);
		logic [LW-1:0] p;
		p = '0;
		for (int i = 0; i < NW; i++) begin
			if (x[i]) begin
				p = LW'(i);
			end
		end
		return p;
	endfunction

	assign busy = (state_q != S_IDLE);
	assign acc = start && !busy;
	assign q_ins = count_q + NW'(1);
	assign lp_ins = msb_pos(q_ins);
	assign lp_pop = msb_pos(count_q);
	// path bits below the leading one, next one at the top
	assign path_ins = NW'(q_ins << (NW - int'(lp_ins)));
	assign bc_node = count_q + NW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q <= 1'b0;
			res_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						res_q <= '0;
						if (cmd.mode == MODE_INSERT) begin
							if (count_q == NW'(HEAP_DEPTH)) begin
								res_q.status <= ST_FULL;
								done_q <= 1'b1;
							end else begin
								count_q <= q_ins;
								state_q <= S_LAUNCH;
							end
						end else begin
							if (count_q == '0) begin
								res_q.status <= ST_EMPTY;
								done_q <= 1'b1;
							end else begin
								count_q <= count_q - NW'(1);
								state_q <= S_POPRD;
							end
						end
					end
				end
				S_LAUNCH: begin
					state_q <= S_RUN;
				end
				S_POPRD: begin
					state_q <= S_POPDAT;
				end
				S_POPDAT: begin
					res_q.status <= ST_OK;
					res_q.out_first_index <= rd0_a[0].first_index;
					res_q.out_second_index <= rd0_a[0].second_index;
					res_q.out_key <= rd0_a[0].key;
					if (count_q == '0) begin
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (|done_v) begin
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ent_q.key <= cmd.key;
			ent_q.first_index <= cmd.first_index;
			ent_q.second_index <= cmd.second_index;
			lim_q <= q_ins;
			path_q <= path_ins;
			lc_q <= lp_pop;
		end
	end

	// launch into the root cell
	always_comb begin
		tok_c[0] = '0;
		tok_c[0].valid = (state_q == S_LAUNCH) || ((state_q == S_POPDAT) && (count_q != '0));
		tok_c[0].op = (state_q == S_LAUNCH) ? MODE_INSERT : MODE_POP;
		node_c[0] = NW'(1);
		lim_c[0] = (state_q == S_LAUNCH) ? lim_q : count_q;
		path_c[0] = path_q;
		ent_c[0] = (state_q == S_LAUNCH) ? ent_q : rd0_a[lc_q];
	end

	assign creq_c[0] = 1'b0;
	assign cnode_c[0] = '0;

	for (genvar L = 0; L < NLV; L++) begin : g_lvl
		localparam int LD = ((2 ** L) < (HEAP_DEPTH - (2 ** L) + 1)) ?
			(2 ** L) : (HEAP_DEPTH - (2 ** L) + 1);

		entry_t cd0_w;
		entry_t cd1_w;

		if (L < NLV - 1) begin : g_child
			assign cd0_w = rd0_a[L+1];
			assign cd1_w = rd1_a[L+1];
		end else begin : g_leaf
			assign cd0_w = '0;
			assign cd1_w = '0;
		end

		mhpq_cell #(
			.LEVEL(L),
			.NW(NW),
			.LVL_DEPTH(LD)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.tok_in(tok_c[L]),
			.node_in(node_c[L]),
			.lim_in(lim_c[L]),
			.path_in(path_c[L]),
			.ent_in(ent_c[L]),
			.tok_out(tok_c[L+1]),
			.node_out(node_c[L+1]),
			.lim_out(lim_c[L+1]),
			.path_out(path_c[L+1]),
			.ent_out(ent_c[L+1]),
			.bc_rd((state_q == S_POPRD) && (lc_q == LW'(L))),
			.bc_node(bc_node),
			.creq(creq_c[L]),
			.cnode(cnode_c[L]),
			.creq_out(creq_c[L+1]),
			.cnode_out(cnode_c[L+1]),
			.cd0(cd0_w),
			.cd1(cd1_w),
			.rd0(rd0_a[L]),
			.rd1(rd1_a[L]),
			.active(active_v[L]),
			.done(done_v[L])
		);
	end

	assign done = done_q;
	assign result = res_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NW'(HEAP_DEPTH))
		else $error("entry count above heap depth");

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(active_v))
		else $error("more than one token in the cell chain");

	a_run_token: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> $onehot(active_v))
		else $error("sequencer waiting with no token in the chain");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> $stable(count_q))
		else $error("entry count changed without a transaction");

endmodule
